// ===== src/psds_pkg.sv =====
// Shared types and constants for the priority sorting DVFS scheduler.
// No dependencies; imported by the controller, the datapath and the top level.
package psds_pkg;

  localparam int TASK_CAPACITY_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LOAD_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_POWER_MW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_POWER_MW   = 2'd2;

  localparam logic [6:0]  LOAD_THRESHOLD_RST  = 7'd70;
  localparam logic [15:0] ACTIVE_POWER_MW_RST = 16'd1200;
  localparam logic [15:0] IDLE_POWER_MW_RST   = 16'd300;

  localparam int PCT_SCALE = 100;
  localparam int QUO_W     = 7;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] exec_time;
    logic [7:0]  priority_req;
    logic        is_last;
  } task_req_t;

  typedef struct packed {
    logic [7:0]  out_task_id;
    logic [7:0]  out_priority;
    logic [15:0] out_exec_time;
    logic [6:0]  load_share;
    logic        high_freq;
    logic [15:0] power_mw;
    logic        idle_report;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] exec_time;
    logic [7:0]  prio;
  } slot_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic emit_task;
    logic emit_idle;
  } psds_cmd_t;

  typedef struct packed {
    logic all_emitted;
    logic scan_done;
    logic div_last;
    logic last_task;
    logic out_free;
  } psds_status_t;

endpackage

// ===== src/psds_ctrl.sv =====
// Sequencer for the scheduler: load, selection scan, divide and emit phases.
// Depends on psds_pkg; drives the datapath through psds_cmd_t only.
module psds_ctrl import psds_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         task_valid,
  input  logic         task_is_last,
  output logic         task_stall,
  input  psds_status_t st,
  output psds_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_START     = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_DIV       = 3'd3;
  localparam logic [2:0] S_EMIT      = 3'd4;
  localparam logic [2:0] S_EMIT_IDLE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign task_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (task_valid) begin
          cmd.load = 1'b1;
          if (task_is_last) state_next = S_START;
        end
      end
      S_START: begin
        cmd.scan_start = 1'b1;
        state_next     = st.all_emitted ? S_EMIT_IDLE : S_SCAN;
      end
      S_SCAN: begin
        if (st.scan_done) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_task = 1'b1;
          state_next    = st.last_task ? S_EMIT_IDLE : S_START;
        end
      end
      S_EMIT_IDLE: begin
        if (st.out_free) begin
          cmd.emit_idle = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_task || cmd.emit_idle) |-> st.out_free)
    else $error("emit issued while result register is occupied");

  a_batch_returns_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_idle |=> !task_stall)
    else $error("idle report did not close the batch");

endmodule

// ===== src/psds_dp.sv =====
// Datapath: task store, running total, min-key selection scan, restoring
// divider, config registers and the result register. Depends on psds_pkg.
module psds_dp import psds_pkg::*; #(
  parameter int TASK_CAPACITY = TASK_CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  task_req_t             task_req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  psds_cmd_t             cmd,
  output psds_status_t          st
);

  localparam int IW = $clog2(TASK_CAPACITY);
  localparam int CW = $clog2(TASK_CAPACITY + 1);
  localparam int TW = 16 + $clog2(TASK_CAPACITY);
  localparam int DW = TW + QUO_W;
  localparam int KW = 8 + IW;

  slot_t mem [TASK_CAPACITY];

  logic [6:0]       load_threshold;
  logic [15:0]      active_power_mw;
  logic [15:0]      idle_power_mw;

  logic [CW-1:0]    count;
  logic [TW-1:0]    total;
  logic [CW-1:0]    emitted;

  logic [CW-1:0]    scan_idx;
  slot_t            rd_data;
  logic [IW-1:0]    rd_idx;
  logic             rd_valid;

  logic [KW-1:0]    prev_key;
  logic             prev_valid;
  logic [KW-1:0]    best_key;
  logic             best_found;
  slot_t            best;

  logic [DW-1:0]    div_rem;
  logic [QUO_W-1:0] quo;
  logic [2:0]       div_bit;

  logic             store_room;
  logic [KW-1:0]    cand_key;
  logic             cand_take;
  logic [DW-1:0]    div_sub;
  logic [6:0]       load_pct;
  logic             hi;

  assign store_room = (count < CW'(TASK_CAPACITY));
  assign cand_key   = {rd_data.prio, rd_idx};
  assign cand_take  = rd_valid && (!prev_valid || cand_key > prev_key) &&
                      (!best_found || cand_key < best_key);
  assign div_sub    = DW'(total) << div_bit;
  assign load_pct   = (total == '0) ? 7'd0 : quo;
  assign hi         = (load_pct > load_threshold);

  assign st.all_emitted = (emitted == count);
  assign st.scan_done   = (scan_idx == count) && !rd_valid;
  assign st.div_last    = (div_bit == 3'd0);
  assign st.last_task   = (emitted == count - CW'(1));
  assign st.out_free    = !result_valid || !result_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      load_threshold  <= LOAD_THRESHOLD_RST;
      active_power_mw <= ACTIVE_POWER_MW_RST;
      idle_power_mw   <= IDLE_POWER_MW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOAD_THRESHOLD:  load_threshold  <= cfg_data[6:0];
        REG_ACTIVE_POWER_MW: active_power_mw <= cfg_data;
        REG_IDLE_POWER_MW:   idle_power_mw   <= cfg_data;
        default: ;
      endcase
    end
  end

  // task store
  always_ff @(posedge clk) begin
    if (cmd.load && store_room) begin
      mem[count[IW-1:0]] <= '{task_id:   task_req.task_id,
                              exec_time: task_req.exec_time,
                              prio:      task_req.priority_req};
    end
    if (cmd.scan_step && scan_idx != count) begin
      rd_data <= mem[scan_idx[IW-1:0]];
      rd_idx  <= scan_idx[IW-1:0];
    end
  end

  // batch control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      total      <= '0;
      emitted    <= '0;
      scan_idx   <= '0;
      rd_valid   <= 1'b0;
      prev_valid <= 1'b0;
      best_found <= 1'b0;
    end else begin
      if (cmd.load && store_room) begin
        count <= count + CW'(1);
        total <= total + TW'(task_req.exec_time);
      end
      if (cmd.scan_start) begin
        scan_idx   <= '0;
        rd_valid   <= 1'b0;
        best_found <= 1'b0;
      end
      if (cmd.scan_step) begin
        rd_valid <= (scan_idx != count);
        if (scan_idx != count) scan_idx <= scan_idx + CW'(1);
        if (cand_take) best_found <= 1'b1;
      end
      if (cmd.emit_task) begin
        emitted    <= emitted + CW'(1);
        prev_valid <= 1'b1;
      end
      if (cmd.emit_idle) begin
        count      <= '0;
        total      <= '0;
        emitted    <= '0;
        prev_valid <= 1'b0;
      end
    end
  end

  // selection and divide payload
  always_ff @(posedge clk) begin
    if (cmd.scan_step && cand_take) begin
      best_key <= cand_key;
      best     <= rd_data;
    end
    if (cmd.emit_task) prev_key <= best_key;
    if (cmd.div_start) begin
      div_rem <= DW'(best.exec_time) * DW'(PCT_SCALE);
      quo     <= '0;
      div_bit <= 3'(QUO_W - 1);
    end
    if (cmd.div_step) begin
      if (div_rem >= div_sub) begin
        div_rem      <= div_rem - div_sub;
        quo[div_bit] <= 1'b1;
      end
      div_bit <= div_bit - 3'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_task || cmd.emit_idle) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_task) begin
      result.out_task_id   <= best.task_id;
      result.out_priority  <= best.prio;
      result.out_exec_time <= best.exec_time;
      result.load_share    <= load_pct;
      result.high_freq     <= hi;
      result.power_mw      <= hi ? active_power_mw : (active_power_mw >> 1);
      result.idle_report   <= 1'b0;
      result.last_result   <= 1'b0;
    end else if (cmd.emit_idle) begin
      result.out_task_id   <= '0;
      result.out_priority  <= '0;
      result.out_exec_time <= '0;
      result.load_share    <= '0;
      result.high_freq     <= 1'b0;
      result.power_mw      <= idle_power_mw;
      result.idle_report   <= 1'b1;
      result.last_result   <= 1'b1;
    end
  end

  a_emitted_bounded: assert property (@(posedge clk) disable iff (rst)
    (emitted <= count) && (count <= CW'(TASK_CAPACITY)))
    else $error("emit or fill count out of range");

  a_emit_has_winner: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_task |-> best_found)
    else $error("task emitted without a selected entry");

  a_load_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_task |-> (load_pct <= 7'd100))
    else $error("load percent above 100");

endmodule

// ===== src/priority_sort_dvfs_scheduler_top.sv =====
// Top level of the priority sorting DVFS scheduler.
// Depends on psds_pkg, psds_ctrl and psds_dp.
//
//  channel   | direction | handshake                   | payload
//  task      | in        | task_valid / task_stall     | task_req (task_req_t)
//  result    | out       | result_valid / result_stall | result (result_t)
//  cfg       | in        | cfg_we                      | cfg_index, cfg_data
//
// Loading accepts one task per cycle. Each scheduled task then takes a start step, a
// scan over the single-port task store, 7 restoring divide steps and an emit
// step; after the last request of a batch, task_stall stays high until the idle
// report is in the result register.
// Reset (rst, synchronous) clears counts and restores the register defaults.
// A stalled result holds the sequencer in its emit step.
module priority_sort_dvfs_scheduler_top import psds_pkg::*; #(
  parameter int TASK_CAPACITY = TASK_CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  task_valid,
  output logic                  task_stall,
  input  task_req_t             task_req,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  psds_cmd_t    cmd;
  psds_status_t st;

  psds_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .task_valid   (task_valid),
    .task_is_last (task_req.is_last),
    .task_stall   (task_stall),
    .st           (st),
    .cmd          (cmd)
  );

  psds_dp #(
    .TASK_CAPACITY (TASK_CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .task_req     (task_req),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking bench for priority_sort_dvfs_scheduler_top: batches of task
// requests are checked against an in-bench scheduler that sorts and rates them.
// Depends on psds_pkg and the RTL under src.
module tb;
  import psds_pkg::*;

  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  task_valid   = 1'b0;
  logic                  task_stall;
  task_req_t             task_req     = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = REG_LOAD_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  task_req_t task_q[$];
  result_t   pending_results[$];

  slot_t       task_store[TASK_CAPACITY_DEF];
  int          stored_count = 0;
  logic [18:0] batch_time   = '0;
  logic [6:0]  thr_reg      = LOAD_THRESHOLD_RST;
  logic [15:0] active_pw    = ACTIVE_POWER_MW_RST;
  logic [15:0] idle_pw      = IDLE_POWER_MW_RST;

  int idle_pct       = 0;
  int stall_pct      = 0;
  int hold_reqs      = 0;
  int holds_done     = 0;
  int hold_left      = 0;
  int tasks_queued   = 0;
  int tasks_accepted = 0;
  int mismatches     = 0;

  priority_sort_dvfs_scheduler_top u_top (
    .clk          (clk),
    .rst          (rst),
    .task_valid   (task_valid),
    .task_stall   (task_stall),
    .task_req     (task_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // stores the request; on the last one of a batch, sorts and rates the batch
  function automatic void schedule_task(input task_req_t t);
    slot_t           sorted[TASK_CAPACITY_DEF];
    slot_t           s;
    result_t         r;
    longint unsigned q;
    int              i;
    int              j;
    if (stored_count < TASK_CAPACITY_DEF) begin
      s.task_id   = t.task_id;
      s.exec_time = t.exec_time;
      s.prio      = t.priority_req;
      task_store[stored_count] = s;
      stored_count++;
      batch_time = batch_time + 19'(t.exec_time);
    end
    if (!t.is_last) return;
    for (i = 0; i < stored_count; i++) begin
      s = task_store[i];
      j = i;
      while (j > 0 && sorted[j-1].prio > s.prio) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = s;
    end
    for (i = 0; i < stored_count; i++) begin
      r = '0;
      r.out_task_id   = sorted[i].task_id;
      r.out_priority  = sorted[i].prio;
      r.out_exec_time = sorted[i].exec_time;
      q = 0;
      if (batch_time != 0) q = (longint'(sorted[i].exec_time) * 100) / batch_time;
      r.load_share   = q[6:0];
      r.high_freq    = (q[6:0] > thr_reg);
      r.power_mw     = r.high_freq ? active_pw : (active_pw >> 1);
      pending_results.push_back(r);
    end
    r = '0;
    r.power_mw    = idle_pw;
    r.idle_report = 1'b1;
    r.last_result = 1'b1;
    pending_results.push_back(r);
    stored_count = 0;
    batch_time   = '0;
  endfunction

  function automatic void check_result(input result_t got);
    result_t exp;
    logic    ok;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp = pending_results.pop_front();
    ok = (got.out_task_id === exp.out_task_id) && (got.out_priority === exp.out_priority)
      && (got.out_exec_time === exp.out_exec_time) && (got.load_share === exp.load_share)
      && (got.high_freq === exp.high_freq) && (got.power_mw === exp.power_mw)
      && (got.idle_report === exp.idle_report) && (got.last_result === exp.last_result);
    if (!ok) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp id %0d prio %0d exec %0d load %0d hf %b pw %0d idle %b last %b",
                 exp.out_task_id, exp.out_priority, exp.out_exec_time, exp.load_share,
                 exp.high_freq, exp.power_mw, exp.idle_report, exp.last_result,
                 " / got id %0d prio %0d exec %0d load %0d hf %b pw %0d idle %b last %b",
                 got.out_task_id, got.out_priority, got.out_exec_time, got.load_share,
                 got.high_freq, got.power_mw, got.idle_report, got.last_result);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      task_valid <= 1'b0;
    end else if (!(task_valid && task_stall)) begin
      if (task_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        task_valid <= 1'b1;
        task_req   <= task_q.pop_front();
      end else begin
        task_valid <= 1'b0;
      end
    end
  end

  // result stall, with long hold-offs on demand
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_reqs != holds_done) begin
      result_stall <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      holds_done   <= holds_done + 1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (task_valid && !task_stall) begin
        tasks_accepted <= tasks_accepted + 1;
        schedule_task(task_req);
      end
      if (result_valid && !result_stall) check_result(result);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LOAD_THRESHOLD:  thr_reg   = val[6:0];
      REG_ACTIVE_POWER_MW: active_pw = val;
      REG_IDLE_POWER_MW:   idle_pw   = val;
      default: ;
    endcase
  endtask

  task automatic push_task(input logic [7:0] id, input logic [15:0] et,
                           input logic [7:0] pr, input logic last);
    task_req_t r;
    r.task_id      = id;
    r.exec_time    = et;
    r.priority_req = pr;
    r.is_last      = last;
    task_q.push_back(r);
    tasks_queued++;
  endtask

  task automatic add_batch(input int n);
    int         k;
    int         mode;
    logic [15:0] et;
    logic [7:0]  pr;
    mode = $urandom_range(3);
    for (k = 0; k < n; k++) begin
      case (mode)
        0: begin et = 16'($urandom_range(65535)); pr = 8'($urandom_range(255)); end
        1: begin et = 16'($urandom_range(20)); pr = 8'($urandom_range(3)); end
        2: begin
          et = (k == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(300));
          pr = 8'($urandom_range(255));
        end
        default: begin
          et = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'd0;
          pr = 8'($urandom_range(7));
        end
      endcase
      push_task(8'($urandom_range(255)), et, pr, k == n - 1);
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 84; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 84; end
      default: begin idle_pct = 23; stall_pct = 23; end
    endcase
  endtask

  task automatic drain;
    while (tasks_accepted != tasks_queued || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int ph;
    int cnt;
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed batches under reset register values
    @(negedge clk);
    push_task(8'd7, 16'd0, 8'd3, 1'b1);
    push_task(8'd255, 16'd65535, 8'd255, 1'b0);
    push_task(8'd0, 16'd0, 8'd0, 1'b0);
    push_task(8'd9, 16'd1000, 8'd128, 1'b1);
    push_task(8'd1, 16'd10, 8'd5, 1'b0);
    push_task(8'd2, 16'd20, 8'd5, 1'b0);
    push_task(8'd3, 16'd30, 8'd1, 1'b0);
    push_task(8'd4, 16'd40, 8'd5, 1'b1);
    for (n = 0; n < 10; n++)
      push_task(8'(8'd100 + n), 16'(n * 7 + 1), 8'(9 - n), n == 9);
    push_task(8'd50, 16'd0, 8'd2, 1'b0);
    push_task(8'd51, 16'd0, 8'd1, 1'b1);
    drain();

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_LOAD_THRESHOLD, 16'd0);
          write_reg(REG_ACTIVE_POWER_MW, 16'd65535);
          write_reg(REG_IDLE_POWER_MW, 16'd0);
        end
        1: begin
          write_reg(REG_LOAD_THRESHOLD, 16'd127);
          write_reg(REG_ACTIVE_POWER_MW, 16'd0);
          write_reg(REG_IDLE_POWER_MW, 16'd65535);
        end
        2: begin
          write_reg(REG_LOAD_THRESHOLD, 16'd100);
          write_reg(REG_ACTIVE_POWER_MW, 16'd1);
          write_reg(REG_IDLE_POWER_MW, 16'($urandom_range(65535)));
        end
        default: begin
          write_reg(REG_LOAD_THRESHOLD, 16'($urandom_range(100)));
          write_reg(REG_ACTIVE_POWER_MW, 16'($urandom_range(65535)));
          write_reg(REG_IDLE_POWER_MW, 16'($urandom_range(65535)));
        end
      endcase
      @(negedge clk);
      set_idling(ph % 4);
      cnt = 0;
      while (cnt < 28) begin
        n = ($urandom_range(7) == 0) ? $urandom_range(11, 9) : $urandom_range(8, 1);
        add_batch(n);
        cnt += n;
      end
      drain();
    end

    // long receiver hold-off while requests keep coming
    write_reg(REG_LOAD_THRESHOLD, 16'd50);
    @(negedge clk);
    set_idling(0);
    hold_reqs++;
    add_batch(8);
    add_batch(8);
    add_batch(10);
    drain();

    if (pending_results.size() != 0) mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== priority_sort_dvfs_scheduler_top.f =====
src/psds_pkg.sv
src/psds_ctrl.sv
src/psds_dp.sv
src/priority_sort_dvfs_scheduler_top.sv
test/tb.sv
